// ===== rtl/lslrp_pkg.sv =====
// Shared types and codes for the level/sid/length record parser.
`default_nettype none
package lslrp_pkg;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CFG_LEVEL_MIN   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LEVEL_MAX   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MAX_CONTENT = 2'd2;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_CONTENT = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_LEVEL = 2'd1;
  localparam logic [1:0] ST_TOO_LONG  = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_buffer;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  record_level;
    logic [15:0] record_sid;
    logic [15:0] record_length;
    logic [7:0]  content_byte;
    logic        record_end;
    logic [1:0]  parse_status;
  } out_t;

endpackage
`default_nettype wire

// ===== rtl/level_sid_length_record_parser_top.sv =====
// Record parser top level: header/content/status results from a byte stream.
// A request's results are written into the result queue when its byte is accepted.
// Throughput: one byte per cycle; a byte that ends the buffer while finishing a
//   header or content byte yields two results, which drain one per cycle, while out_ready
//   is high, from the four-entry result queue. Input is ready while it has two free slots.
// Reset: asynchronous active low; parser back to level phase, no error,
//   registers at level_min 0, level_max 3, max_content_length 1024, queue empty.
`default_nettype none
module level_sid_length_record_parser_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire lslrp_pkg::in_t                      in_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output lslrp_pkg::out_t                          out_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [lslrp_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  wire logic [lslrp_pkg::CfgDataW-1:0]      cfg_data_i
);

  typedef enum logic [2:0] {
    PH_LEVEL,
    PH_SID_HI,
    PH_SID_LO,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_CONTENT,
    PH_SKIP
  } phase_e;

  localparam int unsigned OqDepth = 4;
  localparam int unsigned OqPtrW  = $clog2(OqDepth);
  localparam int unsigned OqCntW  = $clog2(OqDepth + 1);

  logic [7:0]  level_min_q, level_max_q;
  logic [15:0] max_len_q;

  phase_e      phase_q, phase_d;
  logic [7:0]  level_q, level_d;
  logic [15:0] sid_q, sid_d;
  logic [7:0]  len_hi_q, len_hi_d;
  logic [15:0] remain_q, remain_d;
  logic [1:0]  err_q, err_d;

  lslrp_pkg::out_t oq_mem [OqDepth];
  logic [OqPtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [OqCntW-1:0] count_q, count_d;

  lslrp_pkg::out_t res0, res1, stat;
  logic [1:0]  n_res;
  logic        in_fire, out_fire;
  logic [7:0]  b;
  logic [15:0] len_full, rem_dec;

  assign in_ready_o  = (count_q <= OqCntW'(OqDepth - 2));
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign out_fire    = out_valid_o & out_ready_i;
  assign out_o       = oq_mem[rptr_q];

  assign b        = in_i.in_byte;
  assign len_full = {len_hi_q, b};
  assign rem_dec  = remain_q - 16'd1;

  always_comb begin
    phase_d  = phase_q;
    level_d  = level_q;
    sid_d    = sid_q;
    len_hi_d = len_hi_q;
    remain_d = remain_q;
    err_d    = err_q;
    res0     = '0;
    res1     = '0;
    stat     = '0;
    n_res    = 2'd0;
    if (in_fire) begin
      case (phase_q)
        PH_LEVEL: begin
          if (b >= level_min_q && b <= level_max_q) begin
            level_d = b;
            phase_d = PH_SID_HI;
          end else begin
            err_d   = lslrp_pkg::ST_BAD_LEVEL;
            phase_d = PH_SKIP;
          end
        end
        PH_SID_HI: begin
          sid_d   = {b, 8'h00};
          phase_d = PH_SID_LO;
        end
        PH_SID_LO: begin
          sid_d   = {sid_q[15:8], b};
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_hi_d = b;
          phase_d  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (len_full > max_len_q) begin
            err_d   = lslrp_pkg::ST_TOO_LONG;
            phase_d = PH_SKIP;
          end else begin
            res0.result_kind   = lslrp_pkg::KIND_HEADER;
            res0.record_level  = level_q;
            res0.record_sid    = sid_q;
            res0.record_length = len_full;
            res0.record_end    = (len_full == 16'd0);
            n_res              = 2'd1;
            remain_d           = len_full;
            phase_d            = (len_full == 16'd0) ? PH_LEVEL : PH_CONTENT;
          end
        end
        PH_CONTENT: begin
          remain_d          = rem_dec;
          res0.result_kind  = lslrp_pkg::KIND_CONTENT;
          res0.content_byte = b;
          res0.record_end   = (rem_dec == 16'd0);
          n_res             = 2'd1;
          if (rem_dec == 16'd0) begin
            phase_d = PH_LEVEL;
          end
        end
        PH_SKIP: begin
        end
        default: begin
          phase_d = PH_LEVEL;
        end
      endcase
      if (in_i.end_of_buffer) begin
        stat.result_kind = lslrp_pkg::KIND_STATUS;
        if (err_d != lslrp_pkg::ST_OK) begin
          stat.parse_status = err_d;
        end else if (phase_d != PH_LEVEL) begin
          stat.parse_status = lslrp_pkg::ST_TRUNCATED;
        end else begin
          stat.parse_status = lslrp_pkg::ST_OK;
        end
        if (n_res == 2'd0) begin
          res0 = stat;
        end else begin
          res1 = stat;
        end
        n_res    = n_res + 2'd1;
        phase_d  = PH_LEVEL;
        err_d    = lslrp_pkg::ST_OK;
        remain_d = 16'd0;
      end
    end
    wptr_d  = wptr_q + OqPtrW'(n_res);
    rptr_d  = rptr_q + OqPtrW'(out_fire);
    count_d = count_q + OqCntW'(n_res) - OqCntW'(out_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_min_q <= 8'd0;
      level_max_q <= 8'd3;
      max_len_q   <= 16'd1024;
      phase_q     <= PH_LEVEL;
      level_q     <= 8'd0;
      sid_q       <= 16'd0;
      len_hi_q    <= 8'd0;
      remain_q    <= 16'd0;
      err_q       <= lslrp_pkg::ST_OK;
      wptr_q      <= '0;
      rptr_q      <= '0;
      count_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lslrp_pkg::CFG_LEVEL_MIN:   level_min_q <= cfg_data_i[7:0];
          lslrp_pkg::CFG_LEVEL_MAX:   level_max_q <= cfg_data_i[7:0];
          lslrp_pkg::CFG_MAX_CONTENT: max_len_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
      phase_q  <= phase_d;
      level_q  <= level_d;
      sid_q    <= sid_d;
      len_hi_q <= len_hi_d;
      remain_q <= remain_d;
      err_q    <= err_d;
      wptr_q   <= wptr_d;
      rptr_q   <= rptr_d;
      count_q  <= count_d;
    end
  end

  // result queue storage
  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      oq_mem[wptr_q] <= res0;
    end
    if (n_res == 2'd2) begin
      oq_mem[wptr_q + OqPtrW'(1)] <= res1;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= OqCntW'(OqDepth))
    else $error("result queue overfilled");

  a_buffer_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.end_of_buffer |=> phase_q == PH_LEVEL && err_q == lslrp_pkg::ST_OK)
    else $error("parser not back to level phase after buffer end");

  a_content_remaining: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CONTENT |-> remain_q != 16'd0)
    else $error("content phase with nothing remaining");

  a_skip_has_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_SKIP |-> err_q != lslrp_pkg::ST_OK)
    else $error("skip phase without error");

  a_status_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.result_kind == lslrp_pkg::KIND_STATUS |->
      out_o.record_length == 16'd0 && out_o.content_byte == 8'd0 && !out_o.record_end)
    else $error("status result carries record fields");

endmodule
`default_nettype wire

// ===== bench/record_stream_checker.sv =====
// Checker for the record parser: predicts header, content and status results and compares them.
module record_stream_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  lslrp_pkg::in_t                 in_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  lslrp_pkg::out_t                out_i,
  input  logic                           cfg_we_i,
  input  logic [lslrp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [lslrp_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                    pending_o,
  output int unsigned                    mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_LEVEL, PH_SID_HI, PH_SID_LO, PH_LEN_HI, PH_LEN_LO, PH_CONTENT, PH_SKIP
  } phase_e;

  phase_e          phase;
  logic [7:0]      lvl_min, lvl_max, held_level, held_len_hi;
  logic [15:0]     max_len, held_sid, remaining;
  logic [1:0]      err_code;
  lslrp_pkg::out_t expected_results[$];
  lslrp_pkg::out_t want;
  int unsigned     mismatches = 0;

  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatches++;
    end
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic eob);
    lslrp_pkg::out_t r;
    logic [15:0]     len;
    logic [1:0]      st;
    r = '0;
    case (phase)
      PH_LEVEL: begin
        if (b >= lvl_min && b <= lvl_max) begin
          held_level = b;
          phase = PH_SID_HI;
        end else begin
          err_code = lslrp_pkg::ST_BAD_LEVEL;
          phase = PH_SKIP;
        end
      end
      PH_SID_HI: begin
        held_sid = {b, 8'h00};
        phase = PH_SID_LO;
      end
      PH_SID_LO: begin
        held_sid[7:0] = b;
        phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        held_len_hi = b;
        phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len = {held_len_hi, b};
        if (len > max_len) begin
          err_code = lslrp_pkg::ST_TOO_LONG;
          phase = PH_SKIP;
        end else begin
          r.result_kind   = lslrp_pkg::KIND_HEADER;
          r.record_level  = held_level;
          r.record_sid    = held_sid;
          r.record_length = len;
          r.record_end    = (len == 16'd0);
          expected_results.push_back(r);
          remaining = len;
          if (len == 16'd0) phase = PH_LEVEL;
          else phase = PH_CONTENT;
        end
      end
      PH_CONTENT: begin
        remaining = remaining - 16'd1;
        r.result_kind  = lslrp_pkg::KIND_CONTENT;
        r.content_byte = b;
        r.record_end   = (remaining == 16'd0);
        expected_results.push_back(r);
        if (remaining == 16'd0) phase = PH_LEVEL;
      end
      default: ;
    endcase
    if (eob) begin
      if (err_code != lslrp_pkg::ST_OK) st = err_code;
      else if (phase != PH_LEVEL) st = lslrp_pkg::ST_TRUNCATED;
      else st = lslrp_pkg::ST_OK;
      r = '0;
      r.result_kind  = lslrp_pkg::KIND_STATUS;
      r.parse_status = st;
      expected_results.push_back(r);
      phase     = PH_LEVEL;
      err_code  = lslrp_pkg::ST_OK;
      remaining = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_min     = 8'd0;
      lvl_max     = 8'd3;
      max_len     = 16'd1024;
      phase       = PH_LEVEL;
      held_level  = '0;
      held_sid    = '0;
      held_len_hi = '0;
      remaining   = '0;
      err_code    = lslrp_pkg::ST_OK;
      expected_results.delete();
      pending_o    <= 0;
      mismatches_o <= mismatches;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d", out_i.result_kind);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("result_kind", 16'(want.result_kind), 16'(out_i.result_kind));
          check_field("record_level", 16'(want.record_level), 16'(out_i.record_level));
          check_field("record_sid", want.record_sid, out_i.record_sid);
          check_field("record_length", want.record_length, out_i.record_length);
          check_field("content_byte", 16'(want.content_byte), 16'(out_i.content_byte));
          check_field("record_end", 16'(want.record_end), 16'(out_i.record_end));
          check_field("parse_status", 16'(want.parse_status), 16'(out_i.parse_status));
        end
      end
      if (in_valid_i && in_ready_i) parse_byte(in_i.in_byte, in_i.end_of_buffer);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lslrp_pkg::CFG_LEVEL_MIN:   lvl_min = cfg_data_i[7:0];
          lslrp_pkg::CFG_LEVEL_MAX:   lvl_max = cfg_data_i[7:0];
          lslrp_pkg::CFG_MAX_CONTENT: max_len = cfg_data_i;
          default: ;
        endcase
      end
      pending_o    <= $unsigned(expected_results.size());
      mismatches_o <= mismatches;
    end
  end

endmodule

// ===== bench/tb_level_sid_length_record_parser_top.sv =====
// Testbench top for the record parser: byte stream stimulus, config phases and verdict.
module tb_level_sid_length_record_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned ItemsPerStep = 255;

  logic                           clk_i     = 1'b0;
  logic                           rst_ni    = 1'b0;
  logic                           in_valid  = 1'b0;
  logic                           in_ready;
  lslrp_pkg::in_t                 in_req    = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  lslrp_pkg::out_t                out_res;
  logic                           cfg_we    = 1'b0;
  logic [lslrp_pkg::CfgIdxW-1:0]  cfg_idx   = lslrp_pkg::CFG_LEVEL_MIN;
  logic [lslrp_pkg::CfgDataW-1:0] cfg_data  = '0;
  int unsigned                    results_pending;
  int unsigned                    mismatches;

  int unsigned cfg_min = 0, cfg_max = 3, cfg_len = 1024;
  int unsigned burst_left = 0;
  int unsigned sent_count = 0;
  int unsigned stall_cycles = 0;
  int unsigned rx_tick = 0;
  logic [7:0]  stream_q[$];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  level_sid_length_record_parser_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_i        (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  record_stream_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_i         (in_req),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_i        (out_res),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .pending_o    (results_pending),
    .mismatches_o (mismatches)
  );

  // receiver: always ready, coin flip, ready when rx_tick[1:0] is zero, or rarely ready
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    case (rx_tick[9:8])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (rx_tick[1:0] == 2'd0);
      default: out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == StallLimit) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_req(input logic [7:0] b, input logic eob);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 60);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid <= 1'b1;
    in_req   <= '{in_byte: b, end_of_buffer: eob};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    burst_left--;
    sent_count++;
  endtask

  task automatic send_stream();
    foreach (stream_q[i]) send_req(stream_q[i], i == stream_q.size() - 1);
    stream_q.delete();
  endtask

  task automatic add_record(input int unsigned level, input int unsigned sid,
                            input int unsigned len, input int unsigned n_content);
    stream_q.push_back(level[7:0]);
    stream_q.push_back(sid[15:8]);
    stream_q.push_back(sid[7:0]);
    stream_q.push_back(len[15:8]);
    stream_q.push_back(len[7:0]);
    repeat (n_content) stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_noise(input int unsigned n);
    repeat (n) stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  function automatic int unsigned good_level();
    return $urandom_range(cfg_max, cfg_min);
  endfunction

  function automatic int bad_level();
    if (cfg_min > cfg_max) return $urandom_range(0, 255);
    if (cfg_min > 0 && (cfg_max == 255 || $urandom_range(0, 1) == 1))
      return $urandom_range(0, cfg_min - 1);
    if (cfg_max < 255) return $urandom_range(cfg_max + 1, 255);
    return -1;
  endfunction

  function automatic int unsigned short_len();
    if (cfg_len <= 40 && $urandom_range(0, 7) == 0) return cfg_len;
    return $urandom_range(0, (cfg_len < 6) ? cfg_len : 6);
  endfunction

  task automatic send_random_buffer();
    int unsigned pick, len, n, keep;
    int          bad;
    logic        range_ok;
    pick     = $urandom_range(0, 99);
    bad      = bad_level();
    range_ok = (cfg_min <= cfg_max);
    if (pick < 60 && range_ok) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        len = short_len();
        add_record(good_level(), $urandom_range(0, 65535), len, len);
      end
    end else if (pick < 75 && range_ok) begin
      if ($urandom_range(0, 1) == 1) begin
        len = short_len();
        add_record(good_level(), $urandom_range(0, 65535), len, len);
      end
      len = (cfg_len == 0) ? 0 : $urandom_range(1, cfg_len);
      n   = (len == 0) ? 0 : $urandom_range(0, (len - 1 < 8) ? len - 1 : 8);
      add_record(good_level(), $urandom_range(0, 65535), len, n);
      if ($urandom_range(0, 2) == 0) begin
        keep = $urandom_range(1, stream_q.size() - 1);
        while (stream_q.size() > keep) void'(stream_q.pop_back());
      end
    end else if (pick < 85 && bad >= 0) begin
      if (range_ok && $urandom_range(0, 1) == 1) begin
        len = short_len();
        add_record(good_level(), $urandom_range(0, 65535), len, len);
      end
      stream_q.push_back(bad[7:0]);
      add_noise($urandom_range(0, 4));
    end else if (pick < 93 && range_ok && cfg_len < 65535) begin
      len = ($urandom_range(0, 1) == 1) ? cfg_len + 1 : $urandom_range(cfg_len + 1, 65535);
      add_record(good_level(), $urandom_range(0, 65535), len, 0);
      add_noise($urandom_range(0, 3));
    end else begin
      add_noise($urandom_range(1, 10));
    end
    send_stream();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input int unsigned lo, input int unsigned hi, input int unsigned len);
    cfg_we   <= 1'b1;
    cfg_idx  <= lslrp_pkg::CFG_LEVEL_MIN;
    cfg_data <= lo[15:0];
    @(posedge clk_i);
    cfg_idx  <= lslrp_pkg::CFG_LEVEL_MAX;
    cfg_data <= hi[15:0];
    @(posedge clk_i);
    cfg_idx  <= lslrp_pkg::CFG_MAX_CONTENT;
    cfg_data <= len[15:0];
    @(posedge clk_i);
    cfg_we  <= 1'b0;
    cfg_min = lo;
    cfg_max = hi;
    cfg_len = len;
  endtask

  int unsigned set_min[6] = '{0, 255, 7, 0, 100, 0};
  int unsigned set_max[6] = '{255, 255, 2, 0, 200, 0};
  int unsigned set_len[6] = '{65535, 0, 16, 1, 8, 0};

  initial begin
    int unsigned target, lo, hi;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // default registers: level 0..3, length up to 1024
    add_record(0, 16'hFFFF, 0, 0);
    send_stream();
    add_record(3, 16'h0000, 2, 0);
    stream_q.push_back(8'hFF);
    stream_q.push_back(8'h00);
    send_stream();
    stream_q = '{8'h04, 8'hAA};
    send_stream();
    add_record(1, 16'h1234, 16'h0401, 0);
    send_stream();
    stream_q = '{8'h02, 8'h80};
    send_stream();
    stream_q = '{8'hFF};
    send_stream();

    target = sent_count + ItemsPerStep;
    while (sent_count < target) send_random_buffer();

    for (int i = 0; i < 6; i++) begin
      drain();
      if (i == 5) begin
        lo = $urandom_range(0, 255);
        hi = $urandom_range(lo, 255);
        write_cfg(lo, hi, $urandom_range(0, 40));
      end else begin
        write_cfg(set_min[i], set_max[i], set_len[i]);
      end
      target = sent_count + ItemsPerStep;
      while (sent_count < target) send_random_buffer();
    end

    drain();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && results_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
